@@ src/fomm_pkg.sv @@
// shared types and constants for the field oriented mecanum mixer
// no dependencies; used by every other file of the block

package fomm_pkg;

  // angle encoder
  localparam int unsigned ANGLE_STEPS = 8192;
  localparam int unsigned ANGLE_W     = $clog2(ANGLE_STEPS);

  // quarter wave: 16384 phase steps per quadrant, sine in Q1.14
  localparam logic [14:0] QTR = 15'd16384;

  // odd polynomial coefficients of the quarter sine, Q30
  localparam logic [30:0] SC1 = 31'd1686629713;
  localparam logic [29:0] SC3 = 30'd693598668;
  localparam logic [26:0] SC5 = 27'd85569306;
  localparam logic [22:0] SC7 = 23'd5026995;
  localparam logic [17:0] SC9 = 18'd172272;

  // field widths
  localparam int unsigned CMD_W  = 16;
  localparam int unsigned RPM_W  = 16;
  localparam int unsigned HALF_W = 16;
  localparam int unsigned SCL_W  = 20;
  localparam int unsigned CFG_W  = 20;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned WHL_W  = 35;

  // register indexes
  localparam logic [IDX_W-1:0] CFG_ZERO_OFFSET = 2'd0;
  localparam logic [IDX_W-1:0] CFG_HALF_TRACK  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_RPM_SCALE   = 2'd2;

  // register reset values
  localparam logic [ANGLE_W-1:0] ZERO_OFFSET_RST = 13'd3392;
  localparam logic [HALF_W-1:0]  HALF_TRACK_RST  = 16'd22938;
  localparam logic [SCL_W-1:0]   RPM_SCALE_RST   = 20'd617472;

  typedef struct packed {
    logic [ANGLE_W-1:0] zero_offset;
    logic [HALF_W-1:0]  half_track;
    logic [SCL_W-1:0]   rpm_scale;
  } cfg_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] cmd_x;
    logic signed [CMD_W-1:0] cmd_y;
    logic signed [CMD_W-1:0] turn_rate;
  } cmd_t;

endpackage

@@ src/fomm_in_if.sv @@
// command channel: valid/ready handshake with yaw reading and velocity command
// depends on fomm_pkg for field widths

interface fomm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [fomm_pkg::ANGLE_W-1:0]         yaw_angle;
  logic signed [fomm_pkg::CMD_W-1:0]    cmd_x;
  logic signed [fomm_pkg::CMD_W-1:0]    cmd_y;
  logic signed [fomm_pkg::CMD_W-1:0]    turn_rate;

  modport source(output valid, yaw_angle, cmd_x, cmd_y, turn_rate, input ready);
  modport sink(input valid, yaw_angle, cmd_x, cmd_y, turn_rate, output ready);
endinterface

@@ src/fomm_out_if.sv @@
// wheel speed channel: valid/ready handshake with four rpm targets and clip flag
// depends on fomm_pkg for field widths

interface fomm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fomm_pkg::RPM_W-1:0]    wheel_one;
  logic signed [fomm_pkg::RPM_W-1:0]    wheel_two;
  logic signed [fomm_pkg::RPM_W-1:0]    wheel_three;
  logic signed [fomm_pkg::RPM_W-1:0]    wheel_four;
  logic                                 clipped;

  modport source(output valid, wheel_one, wheel_two, wheel_three, wheel_four, clipped,
                 input ready);
  modport sink(input valid, wheel_one, wheel_two, wheel_three, wheel_four, clipped,
               output ready);
endinterface

@@ src/fomm_phase.sv @@
// angle stage: offset removal, 16-bit phase and quadrant folding for sine and cosine
// depends on fomm_pkg

module fomm_phase (
  input  logic                           clk,
  input  logic                           en,
  input  fomm_pkg::cfg_t                 cfg,
  input  logic [fomm_pkg::ANGLE_W-1:0]   yaw,
  output logic [14:0]                    q_sin,
  output logic                           neg_sin,
  output logic [14:0]                    q_cos,
  output logic                           neg_cos
);

  logic [fomm_pkg::ANGLE_W-1:0] ya;
  logic [fomm_pkg::ANGLE_W-1:0] zo;
  logic [fomm_pkg::ANGLE_W:0]   diff;
  logic [fomm_pkg::ANGLE_W-1:0] d;
  logic [15:0]                  ps;
  logic [15:0]                  pc;
  logic [14:0]                  q_sin_nxt;
  logic [14:0]                  q_cos_nxt;
  logic [14:0]                  q_sin_r;
  logic [14:0]                  q_cos_r;
  logic                         neg_sin_r;
  logic                         neg_cos_r;

  // offset removal modulo one turn, then scale to 65536 steps per turn
  always_comb begin
    ya   = fomm_pkg::ANGLE_W'(yaw % fomm_pkg::ANGLE_STEPS);
    zo   = fomm_pkg::ANGLE_W'(cfg.zero_offset % fomm_pkg::ANGLE_STEPS);
    diff = {1'b0, ya} + (fomm_pkg::ANGLE_W + 1)'(fomm_pkg::ANGLE_STEPS) - {1'b0, zo};
    d    = fomm_pkg::ANGLE_W'(diff % fomm_pkg::ANGLE_STEPS);
    ps   = 16'((33'(d) * 33'd65536) / fomm_pkg::ANGLE_STEPS);
    pc   = ps + 16'(fomm_pkg::QTR);
  end

  // fold into the first quadrant, odd quadrants mirrored
  always_comb begin
    q_sin_nxt = ps[14] ? fomm_pkg::QTR - {1'b0, ps[13:0]} : {1'b0, ps[13:0]};
    q_cos_nxt = pc[14] ? fomm_pkg::QTR - {1'b0, pc[13:0]} : {1'b0, pc[13:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_sin_r   <= q_sin_nxt;
      q_cos_r   <= q_cos_nxt;
      neg_sin_r <= ps[15];
      neg_cos_r <= pc[15];
    end
  end

  assign q_sin   = q_sin_r;
  assign neg_sin = neg_sin_r;
  assign q_cos   = q_cos_r;
  assign neg_cos = neg_cos_r;

endmodule

@@ src/fomm_sine.sv @@
// quarter sine by pipelined Horner evaluation, one multiply per stage, six stages
// depends on fomm_pkg for the coefficients

module fomm_sine (
  input  logic                   clk,
  input  logic                   en,
  input  logic [14:0]            q,
  input  logic                   neg,
  output logic signed [15:0]     val
);

  logic [16:0]        u_r   [2:6];
  logic [16:0]        u2_r  [2:5];
  logic               neg_r [2:6];
  logic [22:0]        r1_r;
  logic [26:0]        r2_r;
  logic [29:0]        r3_r;
  logic [30:0]        r4_r;
  logic signed [15:0] val_r;

  logic [33:0] sq;
  logic [34:0] m9;
  logic [39:0] m7;
  logic [43:0] m5;
  logic [46:0] m3;
  logic [47:0] m1;
  logic [32:0] rnd;
  logic [16:0] s;
  logic [14:0] s_cap;
  logic [16:0] u_nxt;
  logic [16:0] u2_nxt;
  logic [22:0] r1_nxt;
  logic [26:0] r2_nxt;
  logic [29:0] r3_nxt;
  logic [30:0] r4_nxt;
  logic signed [15:0] val_nxt;

  // argument in Q16 and its square
  always_comb begin
    u_nxt  = {q, 2'b00};
    sq     = 34'(u_nxt) * 34'(u_nxt);
    u2_nxt = sq[32:16];
  end

  // Horner steps, highest term first
  always_comb begin
    m9     = 35'(fomm_pkg::SC9) * 35'(u2_r[2]);
    r1_nxt = fomm_pkg::SC7 - 23'(m9[34:16]);
    m7     = 40'(r1_r) * 40'(u2_r[3]);
    r2_nxt = fomm_pkg::SC5 - 27'(m7[39:16]);
    m5     = 44'(r2_r) * 44'(u2_r[4]);
    r3_nxt = fomm_pkg::SC3 - 30'(m5[43:16]);
    m3     = 47'(r3_r) * 47'(u2_r[5]);
    r4_nxt = fomm_pkg::SC1 - 31'(m3[46:16]);
  end

  // final odd multiply, round to Q1.14, cap and apply the half-wave sign
  always_comb begin
    m1      = 48'(r4_r) * 48'(u_r[6]);
    rnd     = 33'(m1[47:16]) + 33'd32768;
    s       = rnd[32:16];
    s_cap   = (s > 17'(fomm_pkg::QTR)) ? fomm_pkg::QTR : s[14:0];
    val_nxt = neg_r[6] ? -16'(s_cap) : 16'(s_cap);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r[2]   <= u_nxt;
      u2_r[2]  <= u2_nxt;
      neg_r[2] <= neg;
      for (int i = 3; i <= 6; i++) begin
        u_r[i]   <= u_r[i-1];
        neg_r[i] <= neg_r[i-1];
      end
      for (int i = 3; i <= 5; i++) begin
        u2_r[i] <= u2_r[i-1];
      end
      r1_r  <= r1_nxt;
      r2_r  <= r2_nxt;
      r3_r  <= r3_nxt;
      r4_r  <= r4_nxt;
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

@@ src/fomm_mix.sv @@
// rotation into the chassis frame and mecanum wheel mixing, three stages
// depends on fomm_pkg for the command and configuration types

module fomm_mix (
  input  logic                                clk,
  input  logic                                en,
  input  fomm_pkg::cfg_t                      cfg,
  input  fomm_pkg::cmd_t                      cmd,
  input  logic signed [15:0]                  sn,
  input  logic signed [15:0]                  cs,
  output logic signed [fomm_pkg::WHL_W-1:0]   w [4]
);

  logic signed [31:0]                pxc_r;
  logic signed [31:0]                pys_r;
  logic signed [31:0]                pyc_r;
  logic signed [31:0]                pxs_r;
  logic signed [31:0]                t8_r;
  logic signed [33:0]                vx_r;
  logic signed [33:0]                vy_r;
  logic signed [31:0]                t9_r;
  logic signed [fomm_pkg::WHL_W-1:0] w_r [4];

  logic signed [16:0] half_s;
  logic signed [32:0] t_full;
  logic signed [33:0] vx_nxt;
  logic signed [33:0] vy_nxt;
  logic signed [fomm_pkg::WHL_W-1:0] ex;
  logic signed [fomm_pkg::WHL_W-1:0] ey;
  logic signed [fomm_pkg::WHL_W-1:0] et;

  // turn term, half_track taken as unsigned
  always_comb begin
    half_s = signed'({1'b0, cfg.half_track});
    t_full = 33'(half_s) * 33'(cmd.turn_rate);
  end

  // rotated velocities in Q28
  always_comb begin
    vx_nxt = (34'(pxc_r) + 34'(pys_r)) <<< 2;
    vy_nxt = (34'(pyc_r) - 34'(pxs_r)) <<< 2;
  end

  // wheel sums
  always_comb begin
    ex = fomm_pkg::WHL_W'(vx_r);
    ey = fomm_pkg::WHL_W'(vy_r);
    et = fomm_pkg::WHL_W'(t9_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxc_r  <= 32'(cmd.cmd_x) * 32'(cs);
      pys_r  <= 32'(cmd.cmd_y) * 32'(sn);
      pyc_r  <= 32'(cmd.cmd_y) * 32'(cs);
      pxs_r  <= 32'(cmd.cmd_x) * 32'(sn);
      t8_r   <= 32'(t_full);
      vx_r   <= vx_nxt;
      vy_r   <= vy_nxt;
      t9_r   <= t8_r;
      w_r[0] <= ey - ex - et;
      w_r[1] <= ex + ey - et;
      w_r[2] <= ex - ey - et;
      w_r[3] <= -ex - ey - et;
    end
  end

  assign w = w_r;

endmodule

@@ src/fomm_rpm.sv @@
// scaling of one wheel speed to rpm with rounding and 16-bit saturation, two stages
// depends on fomm_pkg for widths

module fomm_rpm (
  input  logic                                clk,
  input  logic                                en,
  input  logic [fomm_pkg::SCL_W-1:0]          scale,
  input  logic signed [fomm_pkg::WHL_W-1:0]   w,
  output logic signed [fomm_pkg::RPM_W-1:0]   rpm,
  output logic                                clip
);

  localparam logic [54:0] ROUND = 55'(1) << 35;

  logic        neg_r;
  logic [36:0] ph_r;
  logic [36:0] pl_r;
  logic signed [fomm_pkg::RPM_W-1:0] rpm_r;
  logic        clip_r;

  logic [33:0] mag;
  logic [54:0] sum;
  logic [18:0] r;
  logic signed [fomm_pkg::RPM_W-1:0] rpm_nxt;
  logic        clip_nxt;

  // magnitude split in two halves for the scale multiply
  always_comb begin
    mag = w[fomm_pkg::WHL_W-1] ? 34'(-w) : 34'(w);
  end

  // recombine, round half away from zero, saturate
  always_comb begin
    sum      = 55'({ph_r, 17'd0}) + 55'(pl_r) + ROUND;
    r        = sum[54:36];
    clip_nxt = 1'b0;
    if (!neg_r) begin
      if (r > 19'd32767) begin
        rpm_nxt  = 16'sh7fff;
        clip_nxt = 1'b1;
      end else begin
        rpm_nxt = signed'(16'(r));
      end
    end else begin
      if (r > 19'd32768) begin
        rpm_nxt  = 16'sh8000;
        clip_nxt = 1'b1;
      end else begin
        rpm_nxt = -signed'(16'(r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r  <= w[fomm_pkg::WHL_W-1];
      ph_r   <= 37'(mag[33:17]) * 37'(scale);
      pl_r   <= 37'(mag[16:0]) * 37'(scale);
      rpm_r  <= rpm_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign rpm  = rpm_r;
  assign clip = clip_r;

endmodule

@@ src/field_oriented_mecanum_mixer.sv @@
// Field oriented mecanum mixer, top level.
// Commands arrive on in_ch (valid/ready): yaw encoder reading plus x, y and turn
// velocity in the turret frame. Each accepted beat yields exactly one beat on
// out_ch carrying four saturated wheel rpm targets and a clip flag.
// Configuration (zero offset, half track, rpm scale) is written through cfg_we,
// cfg_index and cfg_wdata; unknown indexes are ignored. The user must write it only
// while the pipeline is empty; the block does not enforce it. Stages: one angle,
// six sine (one Horner multiply each), three mixing and two rpm. Throughput is one
// beat per cycle unless out_ch stalls; the whole pipeline advances together.
// in_ch.ready is high whenever the output register is empty or being taken, so a
// stall on out_ch freezes every stage in place and nothing is lost or repeated.
// Synchronous active-low reset empties the pipeline and restores register defaults.
// depends on fomm_pkg, fomm_in_if, fomm_out_if, fomm_phase, fomm_sine, fomm_mix,
// fomm_rpm

module field_oriented_mecanum_mixer (
  input  logic                                clk,
  input  logic                                rst_n,
  fomm_in_if.sink                             in_ch,
  fomm_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [fomm_pkg::IDX_W-1:0]          cfg_index,
  input  logic [fomm_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int unsigned DEPTH = 12;

  fomm_pkg::cfg_t cfg_r;
  fomm_pkg::cfg_t cfg_nxt;
  fomm_pkg::cmd_t cmd_r [1:7];
  logic [DEPTH:1] v_r;
  logic           en;

  logic [14:0] q_sin;
  logic [14:0] q_cos;
  logic        neg_sin;
  logic        neg_cos;
  logic signed [15:0] sn;
  logic signed [15:0] cs;
  logic signed [fomm_pkg::WHL_W-1:0] w [4];
  logic signed [fomm_pkg::RPM_W-1:0] rpm [4];
  logic [3:0]  clip;

  // global advance: the output register is free or being emptied
  assign en          = !v_r[DEPTH] || out_ch.ready;
  assign in_ch.ready = en;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        fomm_pkg::CFG_ZERO_OFFSET: cfg_nxt.zero_offset = cfg_wdata[fomm_pkg::ANGLE_W-1:0];
        fomm_pkg::CFG_HALF_TRACK:  cfg_nxt.half_track  = cfg_wdata[fomm_pkg::HALF_W-1:0];
        fomm_pkg::CFG_RPM_SCALE:   cfg_nxt.rpm_scale   = cfg_wdata[fomm_pkg::SCL_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_offset <= fomm_pkg::ZERO_OFFSET_RST;
      cfg_r.half_track  <= fomm_pkg::HALF_TRACK_RST;
      cfg_r.rpm_scale   <= fomm_pkg::RPM_SCALE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DEPTH-1:1], in_ch.valid};
    end
  end

  // command delay line alongside the angle and sine stages
  always_ff @(posedge clk) begin
    if (en) begin
      cmd_r[1].cmd_x     <= in_ch.cmd_x;
      cmd_r[1].cmd_y     <= in_ch.cmd_y;
      cmd_r[1].turn_rate <= in_ch.turn_rate;
      for (int i = 2; i <= 7; i++) begin
        cmd_r[i] <= cmd_r[i-1];
      end
    end
  end

  fomm_phase u_phase (
    .clk     (clk),
    .en      (en),
    .cfg     (cfg_r),
    .yaw     (in_ch.yaw_angle),
    .q_sin   (q_sin),
    .neg_sin (neg_sin),
    .q_cos   (q_cos),
    .neg_cos (neg_cos)
  );

  fomm_sine u_sin (
    .clk (clk),
    .en  (en),
    .q   (q_sin),
    .neg (neg_sin),
    .val (sn)
  );

  fomm_sine u_cos (
    .clk (clk),
    .en  (en),
    .q   (q_cos),
    .neg (neg_cos),
    .val (cs)
  );

  fomm_mix u_mix (
    .clk (clk),
    .en  (en),
    .cfg (cfg_r),
    .cmd (cmd_r[7]),
    .sn  (sn),
    .cs  (cs),
    .w   (w)
  );

  // one scaler per wheel
  for (genvar k = 0; k < 4; k++) begin : g_rpm
    fomm_rpm u_rpm (
      .clk   (clk),
      .en    (en),
      .scale (cfg_r.rpm_scale),
      .w     (w[k]),
      .rpm   (rpm[k]),
      .clip  (clip[k])
    );
  end

  // result beat
  assign out_ch.valid       = v_r[DEPTH];
  assign out_ch.wheel_one   = rpm[0];
  assign out_ch.wheel_two   = rpm[1];
  assign out_ch.wheel_three = rpm[2];
  assign out_ch.wheel_four  = rpm[3];
  assign out_ch.clipped     = |clip;

endmodule
